@@ hw/rtl/nfad_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfad_pkg
// Shared constants and types for the NFA to DFA subset construction block.
// ----------------------------------------------------------------------------
package nfad_pkg;
    localparam int MAX_STATES     = 16;
    localparam int MAX_SYMBOLS    = 8;
    localparam int MAX_DFA_STATES = 64;

    localparam int ST_W   = 5;
    localparam int SYM_W  = 3;
    localparam int NSYM_W = 4;
    localparam int MASK_W = 16;
    localparam int CNT_W  = 7;
    localparam int NFA_AW = 7;   // state index (4) + symbol (3)
    localparam int DFA_AW = 6;
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;

    typedef enum logic [1:0] {
        K_ADD     = 2'd0,
        K_RESTART = 2'd1,
        K_EXPAND  = 2'd2,
        K_CLEAR   = 2'd3
    } t_kind;

    typedef enum logic [CFG_AW-1:0] {
        CFG_NUM_STATES  = 2'd0,
        CFG_NUM_SYMBOLS = 2'd1,
        CFG_START_STATE = 2'd2,
        CFG_FINAL_MASK  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ST_W-1:0]   from_state;
        logic [SYM_W-1:0]  symbol_index;
        logic [ST_W-1:0]   to_state;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0] source_subset;
        logic [SYM_W-1:0]  row_symbol;
        logic [MASK_W-1:0] target_subset;
        logic              target_is_new;
        logic              source_is_final;
        logic              target_is_final;
        logic              all_done;
        logic              table_full;
        logic              last_row;
    } t_out_item;
endpackage

@@ hw/rtl/nfad_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfad_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface nfad_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/nfad_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfad_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nfad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/nfad_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfad_engine
// Sequencer: transition table updates, clearing sweep, row gathering,
// DFA table search and insertion, result register.
// ----------------------------------------------------------------------------
module nfad_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [nfad_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [nfad_pkg::CFG_DW-1:0] i_cfg_data,
    nfad_stream_if.sink                s_in,
    nfad_stream_if.source              m_out
);
    import nfad_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_ADD_RD, S_ADD_WR, S_SRC_RD, S_SRC_WAIT,
        S_GATHER, S_SEARCH, S_EMIT, S_DONE_EMIT
    } t_state;

    t_state              r_state;
    logic [ST_W-1:0]     r_num_states;
    logic [NSYM_W-1:0]   r_num_symbols;
    logic [ST_W-1:0]     r_start_state;
    logic [MASK_W-1:0]   r_final_mask;

    logic [CNT_W-1:0]    r_dfa_count;
    logic [CNT_W-1:0]    r_cursor;
    logic [NFA_AW:0]     r_clr_cnt;
    t_in_item            r_item;
    logic [MASK_W-1:0]   r_src;
    logic [MASK_W-1:0]   r_tgt;
    logic [SYM_W-1:0]    r_sym;
    logic [ST_W-1:0]     r_st;       // gather index, one past the last read issued
    logic [CNT_W-1:0]    r_idx;      // search index
    logic                r_rd_pend;
    t_out_item           r_row;      // finished row, waiting for the result register
    t_out_item           r_out;
    logic                r_out_vld;

    // effective configuration
    logic [ST_W-1:0]     ns;
    logic [NSYM_W-1:0]   nsym;
    logic [MASK_W-1:0]   act;
    logic [MASK_W-1:0]   fin;
    logic [ST_W-1:0]     start_eff;
    always_comb begin
        ns = (r_num_states == '0) ? ST_W'(1) :
             (r_num_states > ST_W'(MAX_STATES)) ? ST_W'(MAX_STATES) : r_num_states;
        nsym = (r_num_symbols == '0) ? NSYM_W'(1) :
               (r_num_symbols > NSYM_W'(MAX_SYMBOLS)) ? NSYM_W'(MAX_SYMBOLS) : r_num_symbols;
        act = MASK_W'((32'd1 << ns) - 32'd1);
        fin = r_final_mask & act;
        start_eff = (r_start_state == '0) ? ST_W'(1) :
                    (r_start_state > ns) ? ns : r_start_state;
    end

    // memories
    logic                nfa_we;
    logic [NFA_AW-1:0]   nfa_waddr, nfa_raddr;
    logic [MASK_W-1:0]   nfa_wdata, nfa_rdata;
    logic                dfa_we;
    logic [DFA_AW-1:0]   dfa_waddr, dfa_raddr;
    logic [MASK_W-1:0]   dfa_wdata, dfa_rdata;

    nfad_ram #(.WIDTH(MASK_W), .DEPTH(MAX_STATES * MAX_SYMBOLS)) u_nfa_ram (
        .i_clk(i_clk), .i_we(nfa_we), .i_waddr(nfa_waddr), .i_wdata(nfa_wdata),
        .i_raddr(nfa_raddr), .o_rdata(nfa_rdata));
    nfad_ram #(.WIDTH(MASK_W), .DEPTH(MAX_DFA_STATES)) u_dfa_ram (
        .i_clk(i_clk), .i_we(dfa_we), .i_waddr(dfa_waddr), .i_wdata(dfa_wdata),
        .i_raddr(dfa_raddr), .o_rdata(dfa_rdata));

    logic accept, out_take, add_ok;
    logic [ST_W-1:0] from_m1, to_m1;
    assign accept   = s_in.valid && s_in.ready;
    assign out_take = m_out.valid && m_out.ready;
    assign s_in.ready = (r_state == S_IDLE);
    assign m_out.valid = r_out_vld;
    assign m_out.data  = r_out;
    assign from_m1 = r_item.from_state - ST_W'(1);
    assign to_m1   = r_item.to_state - ST_W'(1);
    assign add_ok = (r_item.from_state != '0) && (r_item.from_state <= ns) &&
                    (r_item.to_state != '0) && (r_item.to_state <= ns) &&
                    ({1'b0, r_item.symbol_index} < nsym);

    // next gather read: skip states not in the source subset
    logic [ST_W-1:0] gth_next;
    logic            gth_any;
    always_comb begin
        gth_next = r_st;
        gth_any  = 1'b0;
        for (int i = MAX_STATES - 1; i >= 0; i--) begin
            if ((ST_W'(i) >= r_st) && (ST_W'(i) < ns) && r_src[i]) begin
                gth_next = ST_W'(i);
                gth_any  = 1'b1;
            end
        end
    end

    logic [MASK_W-1:0] tgt_acc;
    logic [CNT_W-1:0]  srch_lim;
    assign tgt_acc = (r_tgt | (r_rd_pend ? nfa_rdata : '0)) & act;
    assign srch_lim = r_dfa_count;

    always_comb begin
        nfa_we    = 1'b0;
        nfa_waddr = {from_m1[3:0], r_item.symbol_index};
        nfa_wdata = nfa_rdata | MASK_W'(1 << to_m1[3:0]);
        nfa_raddr = {from_m1[3:0], r_item.symbol_index};
        dfa_we    = 1'b0;
        dfa_waddr = DFA_AW'(0);
        dfa_wdata = MASK_W'(1 << (start_eff - ST_W'(1)));
        dfa_raddr = r_cursor[DFA_AW-1:0];
        unique case (r_state)
            S_CLR: begin
                nfa_we    = 1'b1;
                nfa_waddr = r_clr_cnt[NFA_AW-1:0];
                nfa_wdata = '0;
            end
            S_IDLE: begin
                if (accept && s_in.data.kind == K_RESTART) dfa_we = 1'b1;
            end
            S_ADD_WR: nfa_we = add_ok;
            S_GATHER: nfa_raddr = {gth_next[3:0], r_sym};
            S_SEARCH: begin
                dfa_raddr = r_rd_pend ? r_idx[DFA_AW-1:0] + DFA_AW'(1) : r_idx[DFA_AW-1:0];
                if (r_idx == srch_lim && r_dfa_count < CNT_W'(MAX_DFA_STATES)) begin
                    dfa_we    = 1'b1;
                    dfa_waddr = r_dfa_count[DFA_AW-1:0];
                    dfa_wdata = r_tgt;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_clr_cnt     <= '0;
            r_num_states  <= ST_W'(16);
            r_num_symbols <= NSYM_W'(8);
            r_start_state <= ST_W'(1);
            r_final_mask  <= '0;
            r_dfa_count   <= '0;
            r_cursor      <= '0;
            r_out_vld     <= 1'b0;
            r_rd_pend     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NUM_STATES:  r_num_states  <= i_cfg_data[ST_W-1:0];
                    CFG_NUM_SYMBOLS: r_num_symbols <= i_cfg_data[NSYM_W-1:0];
                    CFG_START_STATE: r_start_state <= i_cfg_data[ST_W-1:0];
                    CFG_FINAL_MASK:  r_final_mask  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_take) r_out_vld <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == (NFA_AW+1)'(MAX_STATES * MAX_SYMBOLS - 1))
                        r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_item <= s_in.data;
                        unique case (t_kind'(s_in.data.kind))
                            K_ADD:     r_state <= S_ADD_RD;
                            K_RESTART: begin
                                r_dfa_count <= CNT_W'(1);
                                r_cursor    <= '0;
                            end
                            K_CLEAR: begin
                                r_clr_cnt <= '0;
                                r_state   <= S_CLR;
                            end
                            K_EXPAND: begin
                                if (r_cursor >= r_dfa_count) r_state <= S_DONE_EMIT;
                                else r_state <= S_SRC_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_ADD_RD: r_state <= S_ADD_WR;
                S_ADD_WR: r_state <= S_IDLE;
                S_SRC_RD: r_state <= S_SRC_WAIT;
                S_SRC_WAIT: begin
                    r_src     <= dfa_rdata & act;
                    r_cursor  <= r_cursor + 1'b1;
                    r_sym     <= '0;
                    r_st      <= '0;
                    r_tgt     <= '0;
                    r_rd_pend <= 1'b0;
                    r_state   <= S_GATHER;
                end
                S_GATHER: begin
                    // one table read per member state, accumulated from the registered read data
                    r_tgt     <= tgt_acc;
                    r_rd_pend <= gth_any;
                    r_st      <= gth_next + ST_W'(1);
                    if (!gth_any) begin
                        r_idx   <= '0;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    // first cycle only issues the read of entry 0; afterwards the
                    // returned entry r_idx is compared while r_idx+1 is read
                    if (r_tgt == '0) begin
                        r_row   <= '{r_src, r_sym, '0, 1'b0, |(r_src & fin), 1'b0,
                                     1'b0, 1'b0, ({1'b0, r_sym} + 4'd1 == nsym)};
                        r_state <= S_EMIT;
                    end else if (r_idx == srch_lim) begin
                        r_row <= '{r_src, r_sym, r_tgt,
                                   r_dfa_count < CNT_W'(MAX_DFA_STATES),
                                   |(r_src & fin), |(r_tgt & fin), 1'b0,
                                   r_dfa_count >= CNT_W'(MAX_DFA_STATES),
                                   ({1'b0, r_sym} + 4'd1 == nsym)};
                        if (r_dfa_count < CNT_W'(MAX_DFA_STATES))
                            r_dfa_count <= r_dfa_count + 1'b1;
                        r_state <= S_EMIT;
                    end else if (r_rd_pend && ((dfa_rdata ^ r_tgt) & act) == '0) begin
                        r_row <= '{r_src, r_sym, r_tgt, 1'b0, |(r_src & fin),
                                   |(r_tgt & fin), 1'b0, 1'b0,
                                   ({1'b0, r_sym} + 4'd1 == nsym)};
                        r_state <= S_EMIT;
                    end else begin
                        if (r_rd_pend) r_idx <= r_idx + 1'b1;
                        r_rd_pend <= 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!r_out_vld) begin
                        r_out     <= r_row;
                        r_out_vld <= 1'b1;
                        r_rd_pend <= 1'b0;
                        if ({1'b0, r_sym} + 4'd1 == nsym) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_sym   <= r_sym + 1'b1;
                            r_st    <= '0;
                            r_tgt   <= '0;
                            r_state <= S_GATHER;
                        end
                    end
                end
                S_DONE_EMIT: begin
                    if (!r_out_vld) begin
                        r_out     <= '{'0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ hw/rtl/nfa_to_dfa_subset_construction_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_to_dfa_subset_construction_top
// Subset construction of a DFA from an NFA held in a transition RAM.
// ----------------------------------------------------------------------------
// channel  dir  payload
// s_in     in   kind, from_state, symbol_index, to_state
// m_out    out  one DFA row per symbol, or an all_done marker
// cfg      in   i_cfg_we / i_cfg_idx / i_cfg_data, write only
//
// Add: read, then write of the transition RAM entry. Clear: a sweep of the whole
// transition RAM. Expand: fetch the source subset, then per symbol one read per
// member state plus a final gather step, a search of the DFA RAM, and a load of
// the result register.
// Reset starts a clearing sweep; no input transfer until it ends.
// A stalled result holds the sequencer at its next row; idle still takes input.
module nfa_to_dfa_subset_construction_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [nfad_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [nfad_pkg::CFG_DW-1:0] i_cfg_data,
    nfad_stream_if.sink                 s_in,
    nfad_stream_if.source               m_out
);
    import nfad_pkg::*;

    nfad_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_in(s_in), .m_out(m_out));
endmodule
